>>> rtl/hec_pkg.sv
// Shared types and constants for the hashed entry cache.
// Used by hec_ctrl, hec_dp and the top level; depends on nothing.
package hec_pkg;

  localparam int HEC_ENTRIES = 64;
  localparam int HEC_BUCKETS = 63;

  // Command codes.
  localparam logic [1:0] CMD_ACQUIRE = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_FIND    = 2'd2;

  // Status codes.
  localparam logic [3:0] ST_HIT      = 4'd0;
  localparam logic [3:0] ST_MISS     = 4'd1;
  localparam logic [3:0] ST_BUSY     = 4'd2;
  localparam logic [3:0] ST_FULL     = 4'd3;
  localparam logic [3:0] ST_NOTFOUND = 4'd4;
  localparam logic [3:0] ST_RELEASED = 4'd5;
  localparam logic [3:0] ST_FREED    = 4'd6;
  localparam logic [3:0] ST_ZERO     = 4'd7;
  localparam logic [3:0] ST_OVERFLOW = 4'd8;

  // Strobes from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic hash_q;
    logic hash_r;
    logic head_ld;
    logic walk_rd;
    logic walk_ck;
    logic alloc_rd;
    logic alloc_wr;
    logic rel_rd;
    logic rel_ck;
    logic rel_fin;
    logic out_ld;
  } hec_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] in_cmd;
    logic       in_oob;
    logic [1:0] cmd;
    logic       walk_end;
    logic       match;
    logic       ref_one;
    logic       head_is_ent;
    logic       free_empty;
  } hec_sts_t;

endpackage

>>> rtl/hec_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module hec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/hec_ctrl.sv
// Sequencing state machine of the hashed entry cache.
// Depends on hec_pkg; drives strobes into hec_dp.
module hec_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  hec_pkg::hec_sts_t sts_i,
  output hec_pkg::hec_ctl_t ctl_o
);
  import hec_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_HASH     = 4'd1;
  localparam logic [3:0] S_MOD      = 4'd2;
  localparam logic [3:0] S_HEAD     = 4'd3;
  localparam logic [3:0] S_WALK_RD  = 4'd4;
  localparam logic [3:0] S_WALK_CK  = 4'd5;
  localparam logic [3:0] S_ALLOC_RD = 4'd6;
  localparam logic [3:0] S_ALLOC_WR = 4'd7;
  localparam logic [3:0] S_REL_RD   = 4'd8;
  localparam logic [3:0] S_REL_CK   = 4'd9;
  localparam logic [3:0] S_REL_FIN  = 4'd10;
  localparam logic [3:0] S_OUT      = 4'd11;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       rel_mode;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign rel_mode    = (sts_i.cmd == CMD_RELEASE);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    ctl_o       = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.accept = 1'b1;
          if (sts_i.in_cmd == CMD_ACQUIRE || sts_i.in_cmd == CMD_FIND) begin
            state_d = S_HASH;
          end else if (sts_i.in_cmd == CMD_RELEASE && !sts_i.in_oob) begin
            state_d = S_REL_RD;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_HASH: begin
        ctl_o.hash_q = 1'b1;
        state_d = S_MOD;
      end
      S_MOD: begin
        ctl_o.hash_r = 1'b1;
        state_d = S_HEAD;
      end
      S_HEAD: begin
        ctl_o.head_ld = 1'b1;
        if (rel_mode && sts_i.head_is_ent) begin
          state_d = S_REL_FIN;
        end else begin
          state_d = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        ctl_o.walk_rd = 1'b1;
        if (!sts_i.walk_end) begin
          state_d = S_WALK_CK;
        end else if (rel_mode) begin
          state_d = S_REL_FIN;
        end else if (sts_i.cmd == CMD_ACQUIRE && !sts_i.free_empty) begin
          state_d = S_ALLOC_RD;
        end else begin
          state_d = S_OUT;
        end
      end
      S_WALK_CK: begin
        ctl_o.walk_ck = 1'b1;
        if (sts_i.match) begin
          state_d = rel_mode ? S_REL_FIN : S_OUT;
        end else begin
          state_d = S_WALK_RD;
        end
      end
      S_ALLOC_RD: begin
        ctl_o.alloc_rd = 1'b1;
        state_d = S_ALLOC_WR;
      end
      S_ALLOC_WR: begin
        ctl_o.alloc_wr = 1'b1;
        state_d = S_OUT;
      end
      S_REL_RD: begin
        ctl_o.rel_rd = 1'b1;
        state_d = S_REL_CK;
      end
      S_REL_CK: begin
        ctl_o.rel_ck = 1'b1;
        if (sts_i.ref_one) begin
          state_d = S_HASH;
        end else begin
          state_d = S_OUT;
        end
      end
      S_REL_FIN: begin
        ctl_o.rel_fin = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          ctl_o.out_ld = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/hec_dp.sv
// Datapath of the hashed entry cache: entry and bucket memories, hash unit,
// chain walk registers and the result register. Depends on hec_pkg, hec_ram.
module hec_dp #(
  parameter int ENTRIES = hec_pkg::HEC_ENTRIES,
  parameter int BUCKETS = hec_pkg::HEC_BUCKETS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        command_i,
  input  logic [15:0]       device_i,
  input  logic [15:0]       number_i,
  input  logic [3:0]        fs_type_i,
  input  logic [5:0]        entry_i,
  output logic [3:0]        status_o,
  output logic [5:0]        slot_o,
  output logic [7:0]        refs_o,
  input  hec_pkg::hec_ctl_t ctl_i,
  output hec_pkg::hec_sts_t sts_o
);
  import hec_pkg::*;

  localparam int AW  = $clog2(ENTRIES);
  localparam int LW  = AW + 1;
  localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SCW = $clog2(ENTRIES + 1);
  localparam int SW  = 18;
  localparam int EW  = 45 + LW;
  localparam logic [LW-1:0] NIL = {LW{1'b1}};
  localparam logic [LW-1:0] ENT_L = LW'(ENTRIES);
  localparam longint unsigned MUL = (longint'(1) << SW) / BUCKETS;
  localparam logic [SW:0] MULV = (SW+1)'(MUL);
  localparam logic [SW:0] BKV  = (SW+1)'(BUCKETS);

  // Key and walk registers.
  logic [1:0]    cmd_q;
  logic [15:0]   dev_q, num_q;
  logic [3:0]    typ_q;
  logic [5:0]    ent_q;
  logic [SW-1:0] sum_q, quo_q;
  logic [BW-1:0] bkt_q;
  logic [LW-1:0] cur_q, head_q, rel_nxt_q;
  logic [LW-1:0] free_q;
  logic [SCW-1:0] steps_q;
  logic          linked_q;
  logic [3:0]    res_st_q;
  logic [5:0]    res_slot_q;
  logic [7:0]    res_refs_q;
  logic [3:0]    st_q;
  logic [5:0]    slot_q;
  logic [7:0]    refs_q;

  // Entry memory with per-entry valid bits.
  logic          ev_q [ENTRIES];
  logic          erv_q;
  logic [AW-1:0] era_q;
  logic [AW-1:0] e_raddr, e_waddr;
  logic          e_we;
  logic [EW-1:0] e_wdata, e_rdata, erd;

  // Bucket memory with per-bucket valid bits.
  logic          bv_q [BUCKETS];
  logic          brv_q;
  logic [BW-1:0] b_raddr;
  logic          b_we;
  logic [LW-1:0] b_wdata, b_rdata, hrd;

  logic [15:0]   e_dev, e_num;
  logic [3:0]    e_typ;
  logic          e_lock;
  logic [7:0]    e_ref;
  logic [LW-1:0] e_nxt, dflt_nxt, ent_l;
  logic          key_match, link_match, walk_end;
  logic [2*SW+1:0] prod1;
  logic [2*SW+1:0] prod2;
  logic [SW:0]   rem1, rem2;
  logic          is_rel, is_acq;

  assign ent_l  = LW'(ent_q);
  assign is_rel = (cmd_q == CMD_RELEASE);
  assign is_acq = (cmd_q == CMD_ACQUIRE);

  // Reads of never-written entries return the reset contents.
  assign dflt_nxt = (era_q == AW'(ENTRIES - 1)) ? NIL : LW'(era_q) + LW'(1);
  assign erd      = erv_q ? e_rdata : {45'd0, dflt_nxt};
  assign e_dev    = erd[EW-1 -: 16];
  assign e_num    = erd[EW-17 -: 16];
  assign e_typ    = erd[EW-33 -: 4];
  assign e_lock   = erd[LW+8];
  assign e_ref    = erd[LW+7:LW];
  assign e_nxt    = erd[LW-1:0];
  assign hrd      = brv_q ? b_rdata : NIL;

  assign key_match  = (e_dev == dev_q) && (e_num == num_q) &&
                      (cmd_q == CMD_FIND || e_typ == typ_q);
  assign link_match = (e_nxt == ent_l);
  assign walk_end   = (cur_q >= ENT_L) || (steps_q == SCW'(ENTRIES));

  // Modulo by the bucket count: reciprocal multiply, then one correction.
  assign prod1 = (2*SW+2)'({1'b0, sum_q}) * (2*SW+2)'(MULV);
  assign prod2 = (2*SW+2)'({1'b0, quo_q}) * (2*SW+2)'(BKV);
  assign rem1  = {1'b0, sum_q} - prod2[SW:0];
  assign rem2  = (rem1 >= BKV) ? (rem1 - BKV) : rem1;
  assign b_raddr = BW'(rem2);

  always_comb begin
    e_raddr = cur_q[AW-1:0];
    if (ctl_i.rel_rd) begin
      e_raddr = AW'(ent_q);
    end else if (ctl_i.alloc_rd) begin
      e_raddr = free_q[AW-1:0];
    end
  end

  always_comb begin
    e_we    = 1'b0;
    e_waddr = cur_q[AW-1:0];
    e_wdata = erd;
    b_we    = 1'b0;
    b_wdata = rel_nxt_q;
    if (ctl_i.walk_ck && is_acq && key_match && !e_lock && e_ref != 8'hFF) begin
      e_we    = 1'b1;
      e_wdata = {e_dev, e_num, e_typ, 1'b1, e_ref + 8'd1, e_nxt};
    end
    if (ctl_i.walk_ck && is_rel && link_match) begin
      e_we    = 1'b1;
      e_wdata = {e_dev, e_num, e_typ, e_lock, e_ref, rel_nxt_q};
    end
    if (ctl_i.rel_ck && !(e_ref == 8'd0) && !(e_ref == 8'd1)) begin
      e_we    = 1'b1;
      e_waddr = AW'(ent_q);
      e_wdata = {e_dev, e_num, e_typ, 1'b0, e_ref - 8'd1, e_nxt};
    end
    if (ctl_i.alloc_wr) begin
      e_we    = 1'b1;
      e_waddr = free_q[AW-1:0];
      e_wdata = {dev_q, num_q, typ_q, 1'b1, 8'd1, head_q};
      b_we    = 1'b1;
      b_wdata = free_q;
    end
    if (ctl_i.rel_fin) begin
      e_we    = 1'b1;
      e_waddr = AW'(ent_q);
      e_wdata = {dev_q, 16'd0, typ_q, 1'b0, 8'd0, linked_q ? free_q : rel_nxt_q};
    end
    if (ctl_i.head_ld && is_rel && hrd == ent_l) begin
      b_we = 1'b1;
    end
  end

  hec_ram #(.WIDTH(EW), .DEPTH(ENTRIES), .AW(AW)) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (e_we),
    .waddr_i(e_waddr),
    .wdata_i(e_wdata),
    .raddr_i(e_raddr),
    .rdata_o(e_rdata)
  );

  hec_ram #(.WIDTH(LW), .DEPTH(BUCKETS), .AW(BW)) u_bucket_ram (
    .clk_i  (clk_i),
    .we_i   (b_we),
    .waddr_i(bkt_q),
    .wdata_i(b_wdata),
    .raddr_i(b_raddr),
    .rdata_o(b_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        ev_q[i] <= 1'b0;
      end
      for (int i = 0; i < BUCKETS; i++) begin
        bv_q[i] <= 1'b0;
      end
      free_q <= '0;
    end else begin
      if (e_we) begin
        ev_q[e_waddr] <= 1'b1;
      end
      if (b_we) begin
        bv_q[bkt_q] <= 1'b1;
      end
      if (ctl_i.alloc_wr) begin
        free_q <= e_nxt;
      end else if (ctl_i.rel_fin && linked_q) begin
        free_q <= ent_l;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    erv_q <= ev_q[e_raddr];
    era_q <= e_raddr;
    brv_q <= bv_q[b_raddr];
    if (ctl_i.accept) begin
      cmd_q      <= command_i;
      dev_q      <= device_i;
      num_q      <= number_i;
      typ_q      <= fs_type_i;
      ent_q      <= entry_i;
      sum_q      <= SW'(device_i) + SW'(number_i) + SW'(fs_type_i);
      linked_q   <= 1'b0;
      res_st_q   <= (command_i == CMD_RELEASE) ? ST_ZERO : ST_NOTFOUND;
      res_slot_q <= (command_i == CMD_RELEASE) ? entry_i : 6'd0;
      res_refs_q <= 8'd0;
    end
    if (ctl_i.hash_q) begin
      quo_q <= prod1[2*SW-1:SW];
    end
    if (ctl_i.hash_r) begin
      bkt_q <= b_raddr;
    end
    if (ctl_i.head_ld) begin
      cur_q   <= hrd;
      head_q  <= hrd;
      steps_q <= '0;
      if (is_rel && hrd == ent_l) begin
        linked_q <= 1'b1;
      end
    end
    if (ctl_i.walk_rd && walk_end && is_acq && free_q >= ENT_L) begin
      res_st_q <= ST_FULL;
    end
    if (ctl_i.walk_ck) begin
      if (is_rel) begin
        if (link_match) begin
          linked_q <= 1'b1;
        end
      end else if (key_match) begin
        res_slot_q <= 6'(cur_q);
        res_refs_q <= e_ref;
        if (cmd_q == CMD_FIND) begin
          res_st_q <= ST_HIT;
        end else if (e_lock) begin
          res_st_q <= ST_BUSY;
        end else if (e_ref == 8'hFF) begin
          res_st_q <= ST_OVERFLOW;
        end else begin
          res_st_q   <= ST_HIT;
          res_refs_q <= e_ref + 8'd1;
        end
      end
      cur_q   <= e_nxt;
      steps_q <= steps_q + SCW'(1);
    end
    if (ctl_i.rel_ck) begin
      if (e_ref == 8'd1) begin
        dev_q     <= e_dev;
        num_q     <= e_num;
        typ_q     <= e_typ;
        rel_nxt_q <= e_nxt;
        sum_q     <= SW'(e_dev) + SW'(e_num) + SW'(e_typ);
      end else if (e_ref != 8'd0) begin
        res_st_q   <= ST_RELEASED;
        res_refs_q <= e_ref - 8'd1;
      end
    end
    if (ctl_i.alloc_wr) begin
      res_st_q   <= ST_MISS;
      res_slot_q <= 6'(free_q);
      res_refs_q <= 8'd1;
    end
    if (ctl_i.rel_fin) begin
      res_st_q   <= ST_FREED;
      res_refs_q <= 8'd0;
    end
    if (ctl_i.out_ld) begin
      st_q   <= res_st_q;
      slot_q <= res_slot_q;
      refs_q <= res_refs_q;
    end
  end

  assign status_o = st_q;
  assign slot_o   = slot_q;
  assign refs_o   = refs_q;

  always_comb begin
    sts_o             = '0;
    sts_o.in_cmd      = command_i;
    sts_o.in_oob      = (32'(entry_i) >= ENTRIES);
    sts_o.cmd         = cmd_q;
    sts_o.walk_end    = walk_end;
    sts_o.match       = is_rel ? link_match : key_match;
    sts_o.ref_one     = (e_ref == 8'd1);
    sts_o.head_is_ent = (hrd == ent_l);
    sts_o.free_empty  = (free_q >= ENT_L);
  end

endmodule

>>> rtl/hashed_entry_cache_with_free_list.sv
// Top level of the hashed entry cache with free list.
// Depends on hec_pkg, hec_ctrl and hec_dp.
//
// A request beat on the input channel (in_valid_i, in_stall_o) carries a
// command with its key or table index. Each request produces exactly one
// result beat on the output channel (out_valid_o, out_stall_i) with status,
// slot and reference count. One request is worked on at a time: in_stall_o
// is high from acceptance until the result has been moved into the output
// register; the next request can be taken in the cycle after that, even while
// that result still waits for the receiver.
// Acquire and find hash the key, then walk the bucket chain until a hit or
// its end; an acquire that misses then allocates a free entry, unless the
// free list is empty. A release whose count stays above zero or was zero
// ends after reading the entry; for the last reference the key is hashed
// and the chain walked up to the entry, which is then cleared.
// The walk reads and then checks each entry because the entry memory has one
// registered read port; the hash is a reciprocal multiply with a correction
// step. While the receiver stalls, the finished result sits in the output
// register and a following request waits in its last state until it can land.
// Reset clears the entry and bucket valid bits, so the block is ready at once.
module hashed_entry_cache_with_free_list #(
  parameter int ENTRIES = hec_pkg::HEC_ENTRIES,
  parameter int BUCKETS = hec_pkg::HEC_BUCKETS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] device_i,
  input  logic [15:0] number_i,
  input  logic [3:0]  fs_type_i,
  input  logic [5:0]  entry_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  status_o,
  output logic [5:0]  slot_o,
  output logic [7:0]  refs_o
);
  import hec_pkg::*;

  hec_ctl_t ctl;
  hec_sts_t sts;

  // The controller sequences hash, chain walk and memory updates.
  hec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // The datapath holds the table memories and the result register.
  hec_dp #(.ENTRIES(ENTRIES), .BUCKETS(BUCKETS)) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .command_i(command_i),
    .device_i (device_i),
    .number_i (number_i),
    .fs_type_i(fs_type_i),
    .entry_i  (entry_i),
    .status_o (status_o),
    .slot_o   (slot_o),
    .refs_o   (refs_o),
    .ctl_i    (ctl),
    .sts_o    (sts)
  );

endmodule
